### design/raqr_pkg.sv
package raqr_pkg;

    localparam int TimeW   = 62;
    localparam int PeriodW = 41;
    localparam int SlotsW  = 17;
    localparam int ValW    = 64;
    localparam int MaxSlots = 65536;
    localparam int NumTiers = 3;

    typedef enum logic [2:0] {
        MET_MEAN   = 3'd0,
        MET_COUNT  = 3'd1,
        MET_SUM    = 3'd2,
        MET_MIN    = 3'd3,
        MET_MAX    = 3'd4,
        MET_SPREAD = 3'd5,
        MET_MIDDLE = 3'd6,
        MET_NONE   = 3'd7
    } t_metric;

    localparam logic [2:0] CFG_TIER_COUNT = 3'd0;
    localparam logic [2:0] CFG_T0_PERIOD  = 3'd1;
    localparam logic [2:0] CFG_T0_SLOTS   = 3'd2;
    localparam logic [2:0] CFG_T1_PERIOD  = 3'd3;
    localparam logic [2:0] CFG_T1_SLOTS   = 3'd4;
    localparam logic [2:0] CFG_T2_PERIOD  = 3'd5;
    localparam logic [2:0] CFG_T2_SLOTS   = 3'd6;

    // divider request / response
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
        logic [63:0] rem;
    } t_div_rsp;

endpackage

### design/raqr_div.sv
module raqr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  raqr_pkg::t_div_req i_req,
    output raqr_pkg::t_div_rsp o_rsp
);
    import raqr_pkg::*;

    logic [63:0] r_quo, n_quo;
    logic [64:0] r_rem, n_rem;
    logic [63:0] r_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [64:0] w_sh;
    logic [64:0] w_dif;

    // one quotient bit per cycle, restoring
    always_comb begin
        w_sh   = {r_rem[63:0], r_quo[63]};
        w_dif  = w_sh - {1'b0, r_den};
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_quo  = i_req.num;
            n_rem  = '0;
            n_cnt  = 7'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_dif[64]) begin
                n_rem = w_dif;
                n_quo = {r_quo[62:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_quo = {r_quo[62:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_req.start) r_den <= i_req.den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem[63:0];
endmodule

### design/ring_archive_query_reader.sv
// Plan transaction: per tier examined a span product, then a compare; then four passes
// on the shared restoring divider, whose last pass sets the registered result.
// Slot transaction: a present mean with a nonzero count on tier one or two adds one
// divider pass. One transaction at a time: the result sits in an output register
// and the next input is taken the cycle after it is accepted.
// Reset (synchronous, active low) loads the default tier registers and clears query state.
module ring_archive_query_reader (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [61:0] i_now_time,
    input  logic [61:0] i_range_from,
    input  logic [61:0] i_range_to,
    input  logic [2:0]  i_metric,
    input  logic [61:0] i_slot_time,
    input  logic signed [63:0] i_slot_sum,
    input  logic [31:0] i_slot_count,
    input  logic signed [63:0] i_slot_min,
    input  logic signed [63:0] i_slot_max,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [40:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [1:0]  o_tier,
    output logic [61:0] o_point_time,
    output logic [61:0] o_last_time,
    output logic [15:0] o_start_slot,
    output logic [16:0] o_run_one_end,
    output logic [16:0] o_run_two_end,
    output logic [16:0] o_total_points,
    output logic signed [63:0] o_point_value,
    output logic        o_present,
    output logic        o_last
);
    import raqr_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SPAN  = 9'b000000010,
        ST_CHK   = 9'b000000100,
        ST_DFROM = 9'b000001000,
        ST_DTO   = 9'b000010000,
        ST_DX    = 9'b000100000,
        ST_DY    = 9'b001000000,
        ST_MEAN  = 9'b010000000,
        ST_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [1:0]  r_tier_count;
    logic [40:0] r_period [NumTiers];
    logic [16:0] r_slots  [NumTiers];

    logic [1:0]  r_act_tier;
    logic [2:0]  r_act_metric;
    logic [61:0] r_exp_time;
    logic [16:0] r_left;
    logic [40:0] r_act_period;

    logic [61:0] r_now, r_from, r_to, r_stime;
    logic [2:0]  r_metric;
    logic signed [63:0] r_sum, r_min, r_max;
    logic [31:0] r_cnt;

    logic [1:0]  r_k;
    logic [57:0] r_span;
    logic [40:0] r_p;
    logic [16:0] r_s;
    logic [61:0] r_first, r_last;
    logic [15:0] r_x;

    logic        r_ovalid;
    logic        r_kind;
    logic [1:0]  r_otier;
    logic [61:0] r_otime, r_olast;
    logic [15:0] r_ostart;
    logic [16:0] r_oend1, r_oend2, r_otot;
    logic signed [63:0] r_oval;
    logic        r_opres, r_olst;

    t_div_req w_req;
    t_div_rsp w_rsp;

    raqr_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    function automatic logic [40:0] eff_p(input logic [40:0] p);
        return (p == '0) ? 41'd1 : p;
    endfunction

    function automatic logic [16:0] eff_s(input logic [16:0] s);
        logic [16:0] v;
        v = s;
        if (s == '0) v = 17'd1;
        else if (s > 17'(MaxSlots)) v = 17'(MaxSlots);
        return v;
    endfunction

    logic [1:0]  w_n;
    logic [40:0] w_pk;
    logic [16:0] w_sk;
    logic        w_hit;
    logic [63:0] w_mag;
    logic [64:0] w_spr;
    logic signed [64:0] w_mid;
    logic [63:0] w_val;
    logic [16:0] w_y;
    logic        w_acc;
    logic        w_reach;

    assign w_n  = (r_tier_count == 2'd0) ? 2'd1 :
                  (r_tier_count > 2'(NumTiers)) ? 2'(NumTiers) : r_tier_count;
    assign w_pk = eff_p(r_period[r_k]);
    assign w_sk = eff_s(r_slots[r_k]);
    assign w_acc = i_valid && o_ready;
    assign o_ready = (r_state == ST_IDLE) && !r_ovalid;
    assign w_hit = (r_stime == r_exp_time);
    assign w_mag = r_sum[63] ? (~r_sum + 64'd1) : r_sum;
    assign w_spr = {r_max[63], r_max} - {r_min[63], r_min};
    assign w_mid = ({r_max[63], r_max} + {r_min[63], r_min}) >>> 1;
    assign w_y   = 17'(w_rsp.rem);
    // one bit wider so from + span cannot wrap
    assign w_reach = {1'b0, r_now} < ({1'b0, r_from} + {5'd0, r_span});

    always_comb begin
        case (r_act_metric)
            MET_COUNT:  w_val = {16'd0, r_cnt, 16'd0};
            MET_SUM:    w_val = r_sum;
            MET_MIN:    w_val = r_min;
            MET_MAX:    w_val = r_max;
            MET_SPREAD: w_val = (w_spr[64] != w_spr[63]) ?
                                (w_spr[64] ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF)
                                : w_spr[63:0];
            MET_MIDDLE: w_val = w_mid[63:0];
            default:    w_val = '0;
        endcase
        if (r_act_tier == 2'd0) w_val = r_sum;
    end

    // divider order: from/P, (from/P)%S, to/P, (to/P)%S
    always_comb begin
        w_req = '0;
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_acc) n_state = i_action ? ST_OUT : ST_SPAN;
            ST_SPAN: n_state = ST_CHK;
            ST_CHK: begin
                if (w_reach || (r_k == w_n - 2'd1)) begin
                    w_req.start = 1'b1;
                    w_req.num = {2'd0, r_from};
                    w_req.den = {23'd0, w_pk};
                    n_state = ST_DFROM;
                end else n_state = ST_SPAN;
            end
            ST_DFROM: if (w_rsp.done) begin
                w_req.start = 1'b1;
                w_req.num = w_rsp.quo;
                w_req.den = {47'd0, r_s};
                n_state = ST_DX;
            end
            ST_DX: if (w_rsp.done) begin
                w_req.start = 1'b1;
                w_req.num = {2'd0, r_to};
                w_req.den = {23'd0, r_p};
                n_state = ST_DTO;
            end
            ST_DTO: if (w_rsp.done) begin
                w_req.start = 1'b1;
                w_req.num = w_rsp.quo;
                w_req.den = {47'd0, r_s};
                n_state = ST_DY;
            end
            ST_DY: if (w_rsp.done) n_state = ST_IDLE;
            ST_MEAN: if (w_rsp.done) n_state = ST_IDLE;
            ST_OUT: begin
                if (r_left != '0 && w_hit && r_act_tier != 2'd0 &&
                    r_act_metric == MET_MEAN && r_cnt != '0) begin
                    w_req.start = 1'b1;
                    w_req.num = w_mag;
                    w_req.den = {32'd0, r_cnt};
                    n_state = ST_MEAN;
                end else n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_tier_count <= 2'd1;
            r_period[0] <= 41'd10000000;
            r_period[1] <= 41'd60000000;
            r_period[2] <= 41'd600000000;
            r_slots[0] <= 17'd65536;
            r_slots[1] <= 17'd65536;
            r_slots[2] <= 17'd65536;
            r_act_tier <= '0;
            r_act_metric <= '0;
            r_exp_time <= '0;
            r_left <= '0;
            r_act_period <= 41'd1;
            r_ovalid <= 1'b0;
            r_k <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TIER_COUNT: r_tier_count <= i_cfg_data[1:0];
                    CFG_T0_PERIOD:  r_period[0] <= i_cfg_data;
                    CFG_T0_SLOTS:   r_slots[0]  <= i_cfg_data[16:0];
                    CFG_T1_PERIOD:  r_period[1] <= i_cfg_data;
                    CFG_T1_SLOTS:   r_slots[1]  <= i_cfg_data[16:0];
                    CFG_T2_PERIOD:  r_period[2] <= i_cfg_data;
                    CFG_T2_SLOTS:   r_slots[2]  <= i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: r_k <= '0;
                ST_CHK: begin
                    if (!(w_reach || (r_k == w_n - 2'd1)))
                        r_k <= r_k + 2'd1;
                end
                ST_DY: if (w_rsp.done) begin
                    // wrapped or single run
                    r_act_tier <= r_k;
                    r_act_metric <= r_metric;
                    r_exp_time <= r_first;
                    r_act_period <= r_p;
                    if ({1'b0, r_x} < w_y) begin
                        r_left <= w_y - {1'b0, r_x};
                        r_oend1 <= w_y;
                        r_oend2 <= '0;
                        r_otot <= w_y - {1'b0, r_x};
                    end else begin
                        r_left <= w_y + r_s - {1'b0, r_x};
                        r_oend1 <= r_s;
                        r_oend2 <= w_y;
                        r_otot <= w_y + r_s - {1'b0, r_x};
                    end
                    r_ovalid <= 1'b1;
                end
                ST_MEAN: if (w_rsp.done) r_ovalid <= 1'b1;
                ST_OUT: begin
                    if (r_left != '0) begin
                        r_exp_time <= r_exp_time + {21'd0, eff_p(r_act_period)};
                        r_left <= r_left - 17'd1;
                    end
                    if (!(r_left != '0 && w_hit && r_act_tier != 2'd0 &&
                          r_act_metric == MET_MEAN && r_cnt != '0))
                        r_ovalid <= 1'b1;
                end
                default: ;
            endcase
        end

        if (w_acc) begin
            r_now <= i_now_time;
            r_from <= i_range_from;
            r_to <= i_range_to;
            r_metric <= i_metric;
            r_stime <= i_slot_time;
            r_sum <= i_slot_sum;
            r_cnt <= i_slot_count;
            r_min <= i_slot_min;
            r_max <= i_slot_max;
        end
        case (r_state)
            ST_SPAN: r_span <= w_pk * w_sk;
            ST_CHK: begin
                r_p <= w_pk;
                r_s <= w_sk;
            end
            ST_DFROM: if (w_rsp.done) r_first <= r_from - w_rsp.rem[61:0];
            ST_DX: if (w_rsp.done) r_x <= w_rsp.rem[15:0];
            ST_DTO: if (w_rsp.done) r_last <= r_to - w_rsp.rem[61:0];
            ST_DY: if (w_rsp.done) begin
                r_kind <= 1'b0;
                r_otier <= r_k;
                r_otime <= r_first;
                r_olast <= r_last;
                r_ostart <= r_x;
                r_oval <= '0;
                r_opres <= 1'b0;
                r_olst <= 1'b0;
            end
            ST_OUT: begin
                r_kind <= 1'b1;
                r_otier <= r_act_tier;
                r_otime <= r_exp_time;
                r_olast <= '0;
                r_ostart <= '0;
                r_oend1 <= '0;
                r_oend2 <= '0;
                r_otot <= '0;
                r_opres <= (r_left != '0) && w_hit;
                r_olst <= (r_left == 17'd1);
                // a mean that needs the divider is overwritten in ST_MEAN
                r_oval <= ((r_left != '0) && w_hit) ? w_val : '0;
            end
            ST_MEAN: if (w_rsp.done)
                r_oval <= r_sum[63] ? (~w_rsp.quo + 64'd1) : w_rsp.quo;
            default: ;
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_kind = r_kind;
    assign o_tier = r_otier;
    assign o_point_time = r_otime;
    assign o_last_time = r_olast;
    assign o_start_slot = r_ostart;
    assign o_run_one_end = r_oend1;
    assign o_run_two_end = r_oend2;
    assign o_total_points = r_otot;
    assign o_point_value = r_oval;
    assign o_present = r_opres;
    assign o_last = r_olst;
endmodule
